[hdl/pcos_pkg.sv]
`timescale 1ns / 1ps

package pcos_pkg;

    // table size and derived widths
    localparam int MAX_OBSTACLES = 64;
    localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);

    // fixed field widths
    localparam int COUNT_W  = 7;
    localparam int SLOT_W   = 6;
    localparam int COORD_W  = 24;
    localparam int RAD_W    = 23;
    localparam int HIDX_W   = 6;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int RSQ_W    = 2 * RAD_W;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // input word
    typedef struct packed {
        logic                      kind;
        logic [SLOT_W-1:0]         entry_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [RAD_W-1:0]          circle_radius;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              hit;
        logic [HIDX_W-1:0] hit_index;
    } t_res_word;

    // one table entry
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
    } t_entry;

    // tag that travels with each table read through the compare pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

[hdl/pcos_table.sv]
`timescale 1ns / 1ps

// Obstacle table: one write port, one read port with registered data.
module pcos_table (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [pcos_pkg::IDX_W-1:0] i_waddr,
    input  pcos_pkg::t_entry           i_wdata,
    input  logic [pcos_pkg::IDX_W-1:0] i_raddr,
    output pcos_pkg::t_entry           o_rdata
);

    pcos_pkg::t_entry r_mem [pcos_pkg::MAX_OBSTACLES];
    pcos_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pcos_dist.sv]
`timescale 1ns / 1ps

// Three-stage compare: |dx|,|dy| -> squares -> sum and compare with r*r.
module pcos_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_flush,
    input  pcos_pkg::t_tag                      i_tag,
    input  pcos_pkg::t_entry                    i_entry,
    input  logic signed [pcos_pkg::COORD_W-1:0] i_px,
    input  logic signed [pcos_pkg::COORD_W-1:0] i_py,
    output pcos_pkg::t_tag                      o_tag,
    output logic                                o_match
);

    localparam int DW = pcos_pkg::COORD_W + 1;

    pcos_pkg::t_tag r_tag1, r_tag2, r_tag3;
    logic [pcos_pkg::COORD_W-1:0]  r_dx, r_dy;
    logic [pcos_pkg::RAD_W-1:0]    r_rad;
    logic [pcos_pkg::SQ_W-1:0]     r_dx2, r_dy2;
    logic [pcos_pkg::RSQ_W-1:0]    r_rr;
    logic                          r_match;

    logic signed [DW-1:0]          w_dx, w_dy;
    logic [DW-1:0]                 w_adx, w_ady;
    logic [pcos_pkg::SQ_W:0]       w_sum;

    // signed differences and magnitudes; magnitude fits in COORD_W bits
    always_comb begin
        w_dx  = {i_px[pcos_pkg::COORD_W-1], i_px} - {i_entry.x[pcos_pkg::COORD_W-1], i_entry.x};
        w_dy  = {i_py[pcos_pkg::COORD_W-1], i_py} - {i_entry.y[pcos_pkg::COORD_W-1], i_entry.y};
        w_adx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
        w_ady = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
        w_sum = {1'b0, r_dx2} + {1'b0, r_dy2};
    end

    // tag chain, cleared by flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // stage 1: magnitudes
        r_dx        <= w_adx[pcos_pkg::COORD_W-1:0];
        r_dy        <= w_ady[pcos_pkg::COORD_W-1:0];
        r_rad       <= i_entry.r;
        // stage 2: squares
        r_dx2       <= r_dx * r_dx;
        r_dy2       <= r_dy * r_dy;
        r_rr        <= r_rad * r_rad;
        // stage 3: compare
        r_match     <= (w_sum <= (pcos_pkg::SQ_W+1)'(r_rr));
    end

    assign o_tag   = r_tag3;
    assign o_match = r_match;

endmodule

[hdl/point_in_circle_obstacle_search.sv]
`timescale 1ns / 1ps

// Channel   Ports                               Handshake
// command   i_cmd (t_in_word)                   accepted when start && !busy
// result    o_res (t_res_word)                  o_res_strobe, one cycle, no stall
// config    i_cfg_wdata (obstacle_count)        written when i_cfg_we
//
// A load word is written straight into the table and gives no result.
// A query scans N = min(count, table size) entries: the table is read one entry
// per cycle into a read/compare pipeline; a hit ends the scan early. A count of
// zero answers in the cycle after accept, with no scan.
// Reset is synchronous: count cleared, scan idle. Table contents are unset.
// The result side cannot stall; busy is high only while a scan runs.
module point_in_circle_obstacle_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pcos_pkg::t_in_word           i_cmd,
    input  logic                         i_cfg_we,
    input  logic [pcos_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic                         o_res_strobe,
    output pcos_pkg::t_res_word          o_res
);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                          r_state, n_state;
    logic [pcos_pkg::COUNT_W-1:0]    r_count;
    logic [pcos_pkg::CNT_W-1:0]      r_limit, n_limit;
    logic [pcos_pkg::CNT_W-1:0]      r_addr, n_addr;
    logic signed [pcos_pkg::COORD_W-1:0] r_px, r_py;
    pcos_pkg::t_tag                  r_rd_tag, n_rd_tag;
    logic                            r_strobe, n_strobe;
    pcos_pkg::t_res_word             r_res, n_res;

    logic                            w_accept;
    logic                            w_load_we;
    logic                            w_issue;
    logic                            w_done;
    logic [pcos_pkg::CNT_W-1:0]      w_lim;
    pcos_pkg::t_entry                w_wdata;
    pcos_pkg::t_entry                w_rdata;
    pcos_pkg::t_tag                  w_cmp_tag;
    logic                            w_cmp_match;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // load path straight into the table
    assign w_load_we = w_accept && (i_cmd.kind == pcos_pkg::KIND_LOAD)
                       && (32'(i_cmd.entry_index) < pcos_pkg::MAX_OBSTACLES);
    assign w_wdata   = '{x: i_cmd.coord_x, y: i_cmd.coord_y, r: i_cmd.circle_radius};

    // count clipped to the table size
    assign w_lim = (32'(r_count) > pcos_pkg::MAX_OBSTACLES)
                   ? pcos_pkg::CNT_W'(pcos_pkg::MAX_OBSTACLES)
                   : pcos_pkg::CNT_W'(r_count);

    // scan ends on the first hit or on the last entry
    assign w_done  = w_cmp_tag.valid && (w_cmp_match || w_cmp_tag.last);
    assign w_issue = (r_state == S_SCAN) && (r_addr < r_limit) && !w_done;

    pcos_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (pcos_pkg::IDX_W'(i_cmd.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[pcos_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    pcos_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_done),
        .i_tag   (r_rd_tag),
        .i_entry (w_rdata),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tag   (w_cmp_tag),
        .o_match (w_cmp_match)
    );

    // sequencer next state
    always_comb begin
        n_state        = r_state;
        n_limit        = r_limit;
        n_addr         = r_addr;
        n_strobe       = 1'b0;
        n_res          = r_res;
        n_rd_tag.valid = w_issue;
        n_rd_tag.last  = ((r_addr + pcos_pkg::CNT_W'(1)) == r_limit);
        n_rd_tag.idx   = r_addr[pcos_pkg::IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.kind == pcos_pkg::KIND_QUERY)) begin
                    n_limit = w_lim;
                    n_addr  = '0;
                    if (w_lim == '0) begin
                        n_strobe = 1'b1;
                        n_res    = '{hit: 1'b0, hit_index: '0};
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_addr = r_addr + pcos_pkg::CNT_W'(1);
                end
                if (w_done) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_res.hit       = w_cmp_match;
                    n_res.hit_index = w_cmp_match ? pcos_pkg::HIDX_W'(w_cmp_tag.idx) : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_limit  <= '0;
            r_addr   <= '0;
            r_strobe <= 1'b0;
            r_res    <= '0;
            r_rd_tag <= '0;
        end else begin
            r_state  <= n_state;
            r_limit  <= n_limit;
            r_addr   <= n_addr;
            r_strobe <= n_strobe;
            r_res    <= n_res;
            r_rd_tag <= n_rd_tag;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= i_cmd.coord_x;
            r_py <= i_cmd.coord_y;
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // a miss always reports index zero
    a_miss_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.hit |-> o_res.hit_index == '0)
        else $error("miss with nonzero index");

    // scan address never runs past the clipped count
    a_addr_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= r_limit)
        else $error("scan address beyond limit");

    // a result is only given once the scan has returned to idle
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> r_state == S_IDLE)
        else $error("result while scanning");

    // no table read is issued outside a scan
    a_issue_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_tag.valid |-> $past(r_state) == S_SCAN)
        else $error("read issued outside scan");

endmodule
